// ===== rtl/tams_pkg.sv =====
// ----------------------------------------------------------------------------
// tams_pkg
// Shared types, widths and helpers for the two-axis motion spreader.
// ----------------------------------------------------------------------------
`default_nettype none

package tams_pkg;

   localparam int TICK_COUNT_BITS_DEF = 16;
   localparam int MOVE_W              = 16;   // step and total width
   localparam int DUR_W               = 16;   // duration field width
   localparam int REQ_DATA_W          = 48;   // delta_x, delta_y, duration
   localparam int RSP_DATA_W          = 32;   // move_x, move_y

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_WRITE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_start;   // take totals and span, clear residues
      logic load_sum;     // residue + total into sum register
      logic div_start;    // load divider numerator
      logic div_step;     // one quotient bit
      logic commit;       // write residues, tick count and result word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic active;       // ticks remain in the run
      logic out_free;     // result register can take a word
   } sts_type;

   // residue width: holds |residue| <= span/2 plus one total, signed
   function automatic int res_width(input int tcb);
      res_width = ((tcb > MOVE_W) ? tcb : MOVE_W) + 2;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tams_axis.sv =====
// ----------------------------------------------------------------------------
// tams_axis
// One axis: rational residue, bit-serial rounding divider, residue update.
// ----------------------------------------------------------------------------
`default_nettype none

module tams_axis
   import tams_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cmd_type                     cmd,
   input  wire logic signed [MOVE_W-1:0]    total,
   input  wire logic [TICK_COUNT_BITS-1:0]  span,
   output logic signed [MOVE_W-1:0]         move
);

   localparam int TW = TICK_COUNT_BITS;
   localparam int RW = res_width(TICK_COUNT_BITS);
   localparam int NW = RW + 1;      // numerator 2|r| + span
   localparam int DW = TW + 1;      // divisor 2*span

   logic signed [RW-1:0] res_ff, res_in;
   logic signed [RW-1:0] sum_ff, sum_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [MOVE_W-1:0]    quo_ff, quo_in;

   logic                 neg;
   logic [RW-1:0]        mag_full;
   logic [NW-1:0]        numer;
   logic [DW:0]          trial;
   logic [DW:0]          den2;
   logic                 qbit;
   logic signed [DW:0]   diff;
   logic signed [DW:0]   half;
   logic signed [RW-1:0] half_ext;

   assign neg      = sum_ff[RW-1];
   assign mag_full = neg ? (~sum_ff + RW'(1)) : sum_ff;
   assign numer    = NW'({mag_full[RW-2:0], 1'b0}) + NW'(span);

   // restoring division step
   assign trial = {rem_ff, num_ff[NW-1]};
   assign den2  = {1'b0, span, 1'b0};
   assign qbit  = (trial >= den2);

   // new |residue| = (rem - span) / 2, exact since rem - span is even
   assign diff     = $signed({1'b0, rem_ff}) - $signed({2'b00, span});
   assign half     = diff >>> 1;
   assign half_ext = RW'(half);

   assign move = neg ? (~quo_ff + MOVE_W'(1)) : quo_ff;

   always_comb begin
      res_in = res_ff;
      sum_in = sum_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load_start) begin
         res_in = '0;
      end
      if (cmd.load_sum) begin
         sum_in = res_ff + RW'(total);
      end
      if (cmd.div_start) begin
         num_in = numer;
         rem_in = '0;
         quo_in = '0;
      end
      if (cmd.div_step) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         rem_in = qbit ? DW'(trial - den2) : DW'(trial);
         quo_in = {quo_ff[MOVE_W-2:0], qbit};
      end
      if (cmd.commit) begin
         res_in = neg ? -half_ext : half_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

// ===== rtl/tams_dp.sv =====
// ----------------------------------------------------------------------------
// tams_dp
// Datapath: run registers, two axis lanes and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tams_dp
   import tams_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output sts_type                     sts,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic [0:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int TW = TICK_COUNT_BITS;

   logic signed [MOVE_W-1:0] total_x_ff, total_x_in;
   logic signed [MOVE_W-1:0] total_y_ff, total_y_in;
   logic [TW-1:0]            span_ff, span_in;
   logic [TW-1:0]            ticks_ff, ticks_in;

   logic                     vld_ff, vld_in;
   logic [MOVE_W-1:0]        mx_ff, mx_in;
   logic [MOVE_W-1:0]        my_ff, my_in;
   logic                     moved_ff, moved_in;
   logic                     last_ff, last_in;

   logic signed [MOVE_W-1:0] move_x;
   logic signed [MOVE_W-1:0] move_y;

   tams_axis #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_axis_x (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .total (total_x_ff),
      .span  (span_ff),
      .move  (move_x)
   );

   tams_axis #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_axis_y (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .total (total_y_ff),
      .span  (span_ff),
      .move  (move_y)
   );

   assign sts.active   = (ticks_ff != '0);
   assign sts.out_free = !vld_ff || rsp_tready;

   always_comb begin
      total_x_in = total_x_ff;
      total_y_in = total_y_ff;
      span_in    = span_ff;
      ticks_in   = ticks_ff;
      if (cmd.load_start) begin
         total_x_in = req_tdata[MOVE_W-1:0];
         total_y_in = req_tdata[2*MOVE_W-1:MOVE_W];
         // duration kept modulo 2^TICK_COUNT_BITS
         span_in    = TW'(req_tdata[2*MOVE_W+DUR_W-1:2*MOVE_W]);
         ticks_in   = TW'(req_tdata[2*MOVE_W+DUR_W-1:2*MOVE_W]);
      end
      if (cmd.commit) begin
         ticks_in = ticks_ff - TW'(1);
      end
   end

   always_comb begin
      vld_in   = vld_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      moved_in = moved_ff;
      last_in  = last_ff;
      if (cmd.commit) begin
         vld_in   = 1'b1;
         mx_in    = move_x;
         my_in    = move_y;
         moved_in = (move_x != '0) || (move_y != '0);
         last_in  = (ticks_ff == TW'(1));
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
         span_ff  <= '0;
         vld_ff   <= 1'b0;
      end else begin
         ticks_ff <= ticks_in;
         span_ff  <= span_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      total_x_ff <= total_x_in;
      total_y_ff <= total_y_in;
      mx_ff      <= mx_in;
      my_ff      <= my_in;
      moved_ff   <= moved_in;
      last_ff    <= last_in;
   end

   assign rsp_tvalid   = vld_ff;
   assign rsp_tdata    = {my_ff, mx_ff};
   assign rsp_tuser[0] = moved_ff;
   assign rsp_tlast    = last_ff;

endmodule

`default_nettype wire

// ===== rtl/tams_ctrl.sv =====
// ----------------------------------------------------------------------------
// tams_ctrl
// Controller: request handshake, divide sequencing, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tams_ctrl
   import tams_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire op_type   op,
   input  wire sts_type  sts,
   output cmd_type       cmd
);

   localparam int DIV_STEPS = res_width(TICK_COUNT_BITS) + 1;
   localparam int CW        = $clog2(DIV_STEPS);
   localparam logic [CW-1:0] LAST_CNT = CW'(DIV_STEPS - 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && (op == OP_TICK) && sts.active) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.load_start = req_tvalid && (op == OP_START);
            cmd.load_sum   = req_tvalid && (op == OP_TICK) && sts.active;
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_WRITE: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_PREP) begin
         cnt_in = LAST_CNT;
      end else if ((state_ff == ST_DIV) && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/two_axis_motion_spreader.sv =====
// ----------------------------------------------------------------------------
// two_axis_motion_spreader
// Spreads a signed (dx, dy) move evenly over a number of ticks.
// ----------------------------------------------------------------------------
// A start word (tuser = 0) loads dx, dy and the duration, clears both
// residues and replaces any run in progress; it makes no result. Each tick
// word (tuser = 1) during a run adds dx and dy to residues kept in units of
// 1/duration, divides by the duration rounding half away from zero, and
// returns that step, so the steps of a run sum exactly to dx and dy. Ticks
// outside a run, and all ticks after a zero duration, make no result.
// Start words and idle ticks finish at accept; the next word may follow.
// A tick that makes a step goes through the prep, divide and write-back
// states before the next accept. With RES_W = max(TICK_COUNT_BITS, 16) + 2,
// the divider in each axis lane retires one quotient bit per cycle over
// RES_W + 1 bits, both axes in parallel. The result sits in an output
// register, so a new word is taken while the last step waits; only the
// next step's write-back waits for rsp_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_motion_spreader
   import tams_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEF   // 4 .. 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request words
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,   // delta_x, delta_y, duration
   input  wire logic [0:0]             req_tuser,   // operation
   // step words
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // move_x, move_y
   output logic [0:0]                  rsp_tuser,   // moved
   output logic                        rsp_tlast    // final_res
);

   cmd_type cmd;
   sts_type sts;
   op_type  op;

   assign op = op_type'(req_tuser[0]);

   // sequencing: accept, numerator prep, bit-serial divide, write-back
   tams_ctrl #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (op),
      .sts        (sts),
      .cmd        (cmd)
   );

   // run state, axis lanes and result register
   tams_dp #(.TICK_COUNT_BITS(TICK_COUNT_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/tams_checker.sv =====
// ----------------------------------------------------------------------------
// tams_checker
// Port-level checks for the two-axis motion spreader, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tams_checker
   import tams_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [0:0]             req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [0:0]             rsp_tuser,
   input wire logic                   rsp_tlast
);

   // no step word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("step word valid after reset");

   // a stalled step word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
          && $stable(rsp_tlast)))
      else $error("stalled step word changed");

   // moved flag matches the step values
   a_moved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata != '0)))
      else $error("moved flag disagrees with steps");

   // a start word never yields a step
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser[0] == OP_START)
       && !(rsp_tvalid && !rsp_tready)) |=> !$rose(rsp_tvalid))
      else $error("step word after start");

   // a new step only appears after a busy cycle, with req_tready low
   a_step_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("step word without divide");

endmodule

bind two_axis_motion_spreader tams_checker u_tams_checker (.*);

`default_nettype wire

// ===== test/two_axis_motion_spreader_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_axis_motion_spreader_test
// Self-checking bench for the two-axis motion spreader.
// ----------------------------------------------------------------------------
// Request words go in on the req_ stream and step words are checked on the
// rsp_ stream against a local predictor of the DDA split. A short directed
// table covers reset, the field extremes, zero duration, restart mid-run and
// idle ticks. After it come random runs: mostly well-formed (start, then
// duration ticks, at times idle ticks after), with cut-short runs, long
// random durations and noise mixed in. Both streams idle and stall in phases.
// ----------------------------------------------------------------------------

module two_axis_motion_spreader_test;
   import tams_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 64;      // well past one divide
   localparam int RANDOM_WORDS = 1900;
   localparam int PLAN_ROWS    = 25;

   // one step word as seen on rsp_
   typedef struct packed {
      logic signed [MOVE_W-1:0] move_x;
      logic signed [MOVE_W-1:0] move_y;
      logic                     moved;
      logic                     final_res;
   } step_word_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_PREDICT,   // predictor decides
      CHK_SILENT,    // no step word may come
      CHK_TYPED      // step word typed into the row
   } check_kind_type;

   typedef struct packed {
      op_type                   op;
      logic signed [MOVE_W-1:0] dx;
      logic signed [MOVE_W-1:0] dy;
      logic [DUR_W-1:0]         dur;
      check_kind_type           chk;
      step_word_type            want;
   } plan_row_type;

   // Directed table. Tick rows carry don't-care data; some carry all ones
   // to show the fields are ignored on a tick.
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // tick straight after reset: idle, nothing comes out
      '{OP_TICK,  0,      0,      0,     CHK_SILENT,  '{0, 0, 0, 0}},
      // extremes in one tick
      '{OP_START, 32767,  -32768, 1,     CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_TYPED,   '{32767, -32768, 1, 1}},
      // run over: idle tick
      '{OP_TICK,  -1,     -1,     65535, CHK_SILENT,  '{0, 0, 0, 0}},
      // zero move: steps of zero, moved low
      '{OP_START, 0,      0,      3,     CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_TYPED,   '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_TYPED,   '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_TYPED,   '{0, 0, 0, 1}},
      // 5/2 rounds away from zero, remainder goes to the last tick
      '{OP_START, 5,      -5,     2,     CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_TYPED,   '{3, -3, 1, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_TYPED,   '{2, -2, 1, 1}},
      // thirds
      '{OP_START, 1,      -1,     3,     CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      // widest span, left unfinished
      '{OP_START, -32768, 32767,  65535, CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      '{OP_TICK,  -1,     -1,     65535, CHK_PREDICT, '{0, 0, 0, 0}},
      // zero duration abandons the run in progress
      '{OP_START, 100,    100,    0,     CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_SILENT,  '{0, 0, 0, 0}},
      // mixed signs over four ticks
      '{OP_START, -7,     3,      4,     CHK_SILENT,  '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}},
      '{OP_TICK,  0,      0,      0,     CHK_PREDICT, '{0, 0, 0, 0}}
   };

   // ------------------------------------------------------------------------
   // clock, reset and DUT
   // ------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // delta_x, delta_y, duration
   logic [0:0]            req_tuser  = '0;   // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // move_x, move_y
   logic [0:0]            rsp_tuser;         // moved
   logic                  rsp_tlast;         // final_res

   always #1 clock = ~clock;

   two_axis_motion_spreader u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ------------------------------------------------------------------------
   // predictor state: the run as the bench believes it to be
   // ------------------------------------------------------------------------
   logic [DUR_W-1:0]         run_left   = '0;
   logic [DUR_W-1:0]         run_span   = '0;
   logic signed [MOVE_W-1:0] run_dx     = '0;
   logic signed [MOVE_W-1:0] run_dy     = '0;
   longint                   residue_x  = 0;   // units of 1/span
   longint                   residue_y  = 0;

   step_word_type pending_steps [$];   // steps owed by the DUT, oldest first
   int            failures      = 0;
   int            words_counted = 0;   // starts plus ticks that make a step
   int            send_idle_pct = 0;
   int            stall_pct     = 0;

   // Add the total into the residue, take the nearest whole step (ties away
   // from zero), keep what is left. Residue stays within span/2 in magnitude.
   function automatic longint split_axis(inout longint residue,
                                         input longint total,
                                         input longint span);
      longint sum_now;
      longint mag;
      longint quo;
      longint step_now;
      sum_now  = residue + total;
      mag      = (sum_now < 0) ? -sum_now : sum_now;
      quo      = (2 * mag + span) / (2 * span);
      step_now = (sum_now < 0) ? -quo : quo;
      if (step_now > 32767)
         step_now = 32767;
      else if (step_now < -32768)
         step_now = -32768;
      residue = sum_now - step_now * span;
      return step_now;
   endfunction

   // Apply one accepted word to the predictor; returns 1 if it owes a step.
   function automatic bit advance_motion(input op_type op,
                                         input logic signed [MOVE_W-1:0] dx,
                                         input logic signed [MOVE_W-1:0] dy,
                                         input logic [DUR_W-1:0] dur,
                                         output step_word_type w);
      longint sx;
      longint sy;
      w = '0;
      if (op == OP_START) begin
         run_dx    = dx;
         run_dy    = dy;
         run_span  = dur;
         run_left  = dur;
         residue_x = 0;
         residue_y = 0;
         return 1'b0;
      end
      if (run_left == '0 || run_span == '0)
         return 1'b0;
      sx = split_axis(residue_x, longint'(run_dx), longint'(run_span));
      sy = split_axis(residue_y, longint'(run_dy), longint'(run_span));
      run_left    = run_left - DUR_W'(1);
      w.move_x    = sx[MOVE_W-1:0];
      w.move_y    = sy[MOVE_W-1:0];
      w.moved     = (sx != 0) || (sy != 0);
      w.final_res = (run_left == '0);
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // request side: called at a falling edge, returns at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_word(input op_type op,
                            input logic signed [MOVE_W-1:0] dx,
                            input logic signed [MOVE_W-1:0] dy,
                            input logic [DUR_W-1:0] dur,
                            input check_kind_type chk,
                            input step_word_type typed);
      step_word_type w;
      bit            owes;
      // sender gaps
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {dur, dy, dx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // word taken at this edge
      owes = advance_motion(op, dx, dy, dur, w);
      case (chk)
         CHK_PREDICT: if (owes) pending_steps.push_back(w);
         CHK_TYPED:   pending_steps.push_back(typed);
         default:     ;
      endcase
      if (op == OP_START || owes)
         words_counted++;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: tready toggled at falling edges, words checked at rising
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch_steps
      step_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_steps.size() == 0) begin
            $error("step word with none expected: x %0d y %0d",
                   $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]));
            failures++;
         end else begin
            want = pending_steps.pop_front();
            check_field("move_x", int'(want.move_x), int'($signed(rsp_tdata[15:0])));
            check_field("move_y", int'(want.move_y), int'($signed(rsp_tdata[31:16])));
            check_field("moved", int'(want.moved), int'(rsp_tuser[0]));
            check_field("final_res", int'(want.final_res), int'(rsp_tlast));
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL two_axis_motion_spreader");
      $finish;
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic signed [MOVE_W-1:0] dx;
      logic signed [MOVE_W-1:0] dy;
      logic [DUR_W-1:0]         dur;
      int                       pick;
      int                       ticks;
      int                       phase;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, no idling
      for (int i = 0; i < PLAN_ROWS; i++)
         send_word(PLAN[i].op, PLAN[i].dx, PLAN[i].dy, PLAN[i].dur,
                   PLAN[i].chk, PLAN[i].want);

      // random runs; idling phase follows progress
      words_counted = 0;
      while (words_counted < RANDOM_WORDS) begin
         phase = words_counted * 4 / RANDOM_WORDS;
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 83; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase

         pick = $urandom_range(99);
         // totals: half full range, half small so rounding ties show up
         if ($urandom_range(1)) begin
            dx = MOVE_W'($urandom);
            dy = MOVE_W'($urandom);
         end else begin
            dx = MOVE_W'(int'($urandom_range(40)) - 20);
            dy = MOVE_W'(int'($urandom_range(40)) - 20);
         end

         if (pick < 70) begin
            // well-formed run: start, then dur ticks, at times with idle ticks after
            dur = ($urandom_range(9) == 0) ? DUR_W'($urandom_range(64, 13))
                                           : DUR_W'($urandom_range(12, 1));
            send_word(OP_START, dx, dy, dur, CHK_PREDICT, '0);
            ticks = int'(dur);
            if ($urandom_range(4) == 0)
               ticks += $urandom_range(2, 1);   // idle ticks past the end
            repeat (ticks)
               send_word(OP_TICK, MOVE_W'($urandom), MOVE_W'($urandom),
                         DUR_W'($urandom), CHK_PREDICT, '0);
         end else if (pick < 88) begin
            // cut-short run, any duration including zero; next start replaces it
            dur = ($urandom_range(3) == 0) ? '0 : DUR_W'($urandom);
            send_word(OP_START, dx, dy, dur, CHK_PREDICT, '0);
            repeat ($urandom_range(5))
               send_word(OP_TICK, MOVE_W'($urandom), MOVE_W'($urandom),
                         DUR_W'($urandom), CHK_PREDICT, '0);
         end else begin
            // noise
            repeat ($urandom_range(3, 1))
               send_word($urandom_range(3) == 0 ? OP_START : OP_TICK,
                         MOVE_W'($urandom), MOVE_W'($urandom),
                         DUR_W'($urandom), CHK_PREDICT, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_steps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("PASS two_axis_motion_spreader");
      else
         $display("FAIL two_axis_motion_spreader");
      $finish;
   end

endmodule
